>>> rtl/pldc_pkg.sv
// shared types and constants for the piecewise linear decay correlation unit
package pldc_pkg;

	localparam int KnotSlots = 3;
	localparam int MaxKnots = 3;
	localparam int KnotIdxW = $clog2(KnotSlots);
	localparam int TimeW = 31;
	localparam int RhoW = 16;
	localparam int DeltaW = 32;
	localparam int CountW = 2;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;
	localparam int DiffRW = RhoW + 1;
	localparam int ProdW = DeltaW + DiffRW;
	localparam int DivW = 48;
	localparam int DivisorW = TimeW;
	localparam int AccW = DivW + 2;
	localparam logic [RhoW-1:0] OneQ15 = RhoW'(32768);
	localparam logic [CountW-1:0] MaxKnotsCode = CountW'(MaxKnots);

	typedef enum logic [CfgIdxW-1:0] {
		REG_SEGMENT_COUNT = 3'd0,
		REG_EPSILON_TIME  = 3'd1,
		REG_RHO_KNOT0     = 3'd2,
		REG_RHO_KNOT1     = 3'd3,
		REG_RHO_KNOT2     = 3'd4,
		REG_TIME_KNOT0    = 3'd5,
		REG_TIME_KNOT1    = 3'd6,
		REG_TIME_KNOT2    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [CountW-1:0]                 segment_count;
		logic [TimeW-1:0]                  epsilon_time;
		logic [KnotSlots-1:0][RhoW-1:0]    rho_knot;
		logic [KnotSlots-1:0][TimeW-1:0]   time_knot;
	} cfg_regs_t;

endpackage

>>> rtl/piecewise_linear_decay_correlation_unit.sv
// top level: correlation coefficient from a time difference on a piecewise linear curve
//
// Command channel: drive delta_time with start high; the item is taken at a rising
// edge where start is high and busy is low. busy stays high until the result is out.
// Result channel: done pulses for one cycle with coefficient and was_clamped valid
// in that cycle; the receiver cannot stall, and both hold until the next result.
// Configuration: cfg_valid with cfg_index and cfg_data writes one register; cfg_ready
// is always high. Write only while busy is low.
// Sequence: a zero or small difference, no knots or a held knot value go to the final
// clamp from the check step or the knot scan. An interpolated value goes through the
// knot scan, the multiply, the divider that produces two quotient bits per cycle over a
// 48-bit dividend, and the final clamp. One item is in flight at a time, so a new item
// is taken only once the last one is done.
// Reset: arst_n clears the sequencer and loads the register defaults (one knot in
// use at 1000.0 with correlation 0, epsilon 0).
module piecewise_linear_decay_correlation_unit
	import pldc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [DeltaW-1:0]   delta_time,
	output logic                done,
	output logic [RhoW-1:0]     coefficient,
	output logic                was_clamped,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FIN
	} state_t;

	cfg_regs_t regs;

	state_t                    state_q;
	logic [TimeW-1:0]          mag_q;
	logic [KnotIdxW-1:0]       idx_q;
	logic [CountW-1:0]         last_q;
	logic [TimeW-1:0]          prev_time_q;
	logic [RhoW-1:0]           prev_rho_q;
	logic signed [DeltaW-1:0]  diff_t_q;
	logic signed [DiffRW-1:0]  diff_r_q;
	logic signed [DeltaW-1:0]  dt_q;
	logic signed [ProdW-1:0]   prod_q;
	logic signed [AccW-1:0]    acc_q;
	logic                      done_q;
	logic [RhoW-1:0]           coef_q;
	logic                      clamp_q;

	logic [DeltaW-1:0]         neg_delta;
	logic [TimeW-1:0]          mag_in;
	logic [CountW-1:0]         knots;
	logic [TimeW-1:0]          cur_time;
	logic [RhoW-1:0]           cur_rho;
	logic signed [DeltaW-1:0]  dt_d;
	logic signed [ProdW-1:0]   prod_neg;
	logic [DeltaW-1:0]         dt_abs;
	logic                      div_start;
	logic                      div_busy;
	logic                      div_done;
	logic [DivW-1:0]           div_q;
	logic signed [AccW-1:0]    q_signed;
	logic                      q_neg;

	pldc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	assign cfg_ready = 1'b1;

	assign neg_delta = DeltaW'(0) - delta_time;
	always_comb begin
		if (delta_time == {1'b1, {(DeltaW-1){1'b0}}}) begin
			mag_in = {TimeW{1'b1}};
		end else if (delta_time[DeltaW-1]) begin
			mag_in = neg_delta[TimeW-1:0];
		end else begin
			mag_in = delta_time[TimeW-1:0];
		end
	end

	assign knots = (regs.segment_count > MaxKnotsCode) ? MaxKnotsCode : regs.segment_count;
	assign cur_time = regs.time_knot[idx_q];
	assign cur_rho = regs.rho_knot[idx_q];
	assign dt_d = $signed({1'b0, cur_time}) - $signed({1'b0, prev_time_q});

	// sign-magnitude operands for the divider
	assign prod_neg = -prod_q;
	assign dt_abs = dt_q[DeltaW-1] ? (DeltaW'(0) - dt_q) : dt_q;
	assign div_start = (state_q == ST_DIV_GO);
	assign q_neg = prod_q[ProdW-1] ^ dt_q[DeltaW-1];
	assign q_signed = q_neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});

	pldc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q[ProdW-1] ? prod_neg[DivW-1:0] : prod_q[DivW-1:0]),
		.divisor  (dt_abs[DivisorW-1:0]),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			idx_q <= '0;
			last_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					idx_q <= KnotIdxW'(1);
					last_q <= knots - CountW'(1);
					if (mag_q == '0 || mag_q < regs.epsilon_time) begin
						state_q <= ST_FIN;
					end else if (knots == '0) begin
						state_q <= ST_FIN;
					end else if (knots == CountW'(1)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (mag_q <= cur_time) begin
						state_q <= (dt_d == '0) ? ST_FIN : ST_MUL;
					end else if (CountW'(idx_q) == last_q) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + KnotIdxW'(1);
					end
				end
				ST_MUL: state_q <= ST_DIV_GO;
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mag_q <= mag_in;
			end
			ST_CHECK: begin
				prev_time_q <= regs.time_knot[0];
				prev_rho_q <= regs.rho_knot[0];
				if (mag_q == '0 || mag_q < regs.epsilon_time) begin
					acc_q <= AccW'(OneQ15);
				end else if (knots == '0) begin
					acc_q <= '0;
				end else begin
					acc_q <= AccW'(regs.rho_knot[0]);
				end
			end
			ST_SCAN: begin
				diff_t_q <= $signed({1'b0, mag_q}) - $signed({1'b0, prev_time_q});
				diff_r_q <= $signed({1'b0, cur_rho}) - $signed({1'b0, prev_rho_q});
				dt_q <= dt_d;
				if (mag_q <= cur_time) begin
					acc_q <= AccW'(prev_rho_q);
				end else begin
					prev_time_q <= cur_time;
					prev_rho_q <= cur_rho;
					acc_q <= AccW'(cur_rho);
				end
			end
			ST_MUL: begin
				prod_q <= ProdW'(diff_t_q) * ProdW'(diff_r_q);
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					acc_q <= $signed({{(AccW-RhoW){1'b0}}, prev_rho_q}) + q_signed;
				end
			end
			ST_FIN: begin
				if (acc_q < 0) begin
					coef_q <= '0;
					clamp_q <= 1'b1;
				end else if (acc_q > $signed(AccW'(OneQ15))) begin
					coef_q <= OneQ15;
					clamp_q <= 1'b1;
				end else begin
					coef_q <= acc_q[RhoW-1:0];
					clamp_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign coefficient = coef_q;
	assign was_clamped = clamp_q;

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("result strobe without finishing step");

	a_div_within_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> busy)
		else $error("divider running while sequencer idle");

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> coefficient <= OneQ15)
		else $error("coefficient above one");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer accepted but block not busy");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV_WAIT)
		else $error("divider finished outside wait state");

endmodule

>>> rtl/pldc_cfg.sv
// configuration register file
module pldc_cfg
	import pldc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_regs_t           regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.segment_count <= CountW'(1);
			regs_q.epsilon_time <= '0;
			regs_q.rho_knot <= '0;
			regs_q.time_knot[0] <= TimeW'(65536000);
			regs_q.time_knot[1] <= '0;
			regs_q.time_knot[2] <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_SEGMENT_COUNT: regs_q.segment_count <= cfg_data[CountW-1:0];
				REG_EPSILON_TIME:  regs_q.epsilon_time <= cfg_data[TimeW-1:0];
				REG_RHO_KNOT0:     regs_q.rho_knot[0] <= cfg_data[RhoW-1:0];
				REG_RHO_KNOT1:     regs_q.rho_knot[1] <= cfg_data[RhoW-1:0];
				REG_RHO_KNOT2:     regs_q.rho_knot[2] <= cfg_data[RhoW-1:0];
				REG_TIME_KNOT0:    regs_q.time_knot[0] <= cfg_data[TimeW-1:0];
				REG_TIME_KNOT1:    regs_q.time_knot[1] <= cfg_data[TimeW-1:0];
				REG_TIME_KNOT2:    regs_q.time_knot[2] <= cfg_data[TimeW-1:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

>>> rtl/pldc_div.sv
// restoring unsigned divider, two quotient bits per cycle
module pldc_div
	import pldc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DivW-1:0]     dividend,
	input  logic [DivisorW-1:0] divisor,
	output logic                busy,
	output logic                done,
	output logic [DivW-1:0]     quotient
);

	localparam int BitsPerCycle = 2;
	localparam int DivSteps = DivW / BitsPerCycle;
	localparam int CntW = $clog2(DivSteps + 1);

	logic [DivisorW-1:0] rem_q;
	logic [DivW-1:0]     quo_q;
	logic [DivisorW-1:0] dsr_q;
	logic [CntW-1:0]     cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DivisorW-1:0] rem_d;
	logic [DivW-1:0]     quo_d;

	always_comb begin
		logic [DivisorW:0] trial;
		rem_d = rem_q;
		quo_d = quo_q;
		for (int k = 0; k < BitsPerCycle; k++) begin
			trial = {rem_d, quo_d[DivW-1]};
			if (trial >= {1'b0, dsr_q}) begin
				trial = trial - {1'b0, dsr_q};
				quo_d = {quo_d[DivW-2:0], 1'b1};
			end else begin
				quo_d = {quo_d[DivW-2:0], 1'b0};
			end
			rem_d = trial[DivisorW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(DivSteps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

endmodule
